@@ rtl/snfc_pkg.sv @@
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer package
// Shared types, command codes and opcode constants.
// ----------------------------------------------------------------------------
package snfc_pkg;

    localparam logic [3:0] CMD_JEDEC   = 4'd0;
    localparam logic [3:0] CMD_DEVID   = 4'd1;
    localparam logic [3:0] CMD_READ    = 4'd2;
    localparam logic [3:0] CMD_PROGRAM = 4'd3;
    localparam logic [3:0] CMD_SECTOR  = 4'd4;
    localparam logic [3:0] CMD_ERASE32 = 4'd5;
    localparam logic [3:0] CMD_ERASE64 = 4'd6;
    localparam logic [3:0] CMD_CHIP    = 4'd7;
    localparam logic [3:0] CMD_WRITE   = 4'd8;
    localparam logic [3:0] CMD_LINK    = 4'd9;

    localparam logic [1:0] KIND_SEND    = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_DUMMY = 8'hFF;
    localparam logic [7:0] OP_ZERO  = 8'h00;

    // Item as it crosses from the front end to the back end.
    typedef struct packed {
        logic [3:0]  cmd;
        logic [23:0] address;
        logic [15:0] length;
        logic [7:0]  data;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] value;
        logic        last;
        logic        status;
    } result_t;

    function automatic logic [7:0] opcode(input logic [2:0] op);
        logic [7:0] r;
        begin
            case (op)
                3'd0:    r = 8'h9F;
                3'd1:    r = 8'h90;
                3'd2:    r = 8'h03;
                3'd3:    r = 8'h02;
                3'd4:    r = 8'h20;
                3'd5:    r = 8'h52;
                3'd6:    r = 8'hD8;
                default: r = 8'hC7;
            endcase
            return r;
        end
    endfunction

endpackage

@@ rtl/snfc_front.sv @@
// ----------------------------------------------------------------------------
// Front end
// Accepts input transactions into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module snfc_front
    import snfc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  q_valid,
    input  logic  q_ready,
    output item_t q_item
);

    item_t      mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (q_valid && q_ready)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !q_ready) |=> count_reg == 2'd2)
        else $error("full queue lost an entry");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 && !in_valid) |=> count_reg == 2'd0)
        else $error("empty queue gained an entry");

endmodule

@@ rtl/snfc_back.sv @@
// ----------------------------------------------------------------------------
// Back end
// Runs the command state machine; emits up to three results per item.
// ----------------------------------------------------------------------------
module snfc_back
    import snfc_pkg::*;
#(
    parameter int PAGE_BYTES = 256,
    parameter int ADDR_BITS  = 24
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    output logic    q_ready,
    input  item_t   q_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    localparam int PW = $clog2(PAGE_BYTES);

    typedef enum logic [3:0] {
        PH_IDLE, PH_WREN, PH_HDR, PH_IDRD, PH_RDATA,
        PH_WAITW, PH_WDATA, PH_POLLC, PH_POLLS
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [2:0]             op_reg, op_next;
    logic [ADDR_BITS-1:0]   addr_reg, addr_next;
    logic [15:0]            left_reg, left_next;
    logic [3:0]             fidx_reg, fidx_next;
    logic [23:0]            acc_reg, acc_next;

    // Result buffer: up to three results of one item, drained in order.
    result_t    buf_reg [3];
    result_t    buf_next [3];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] pos_reg;
    logic [1:0] n;

    logic       take, ok;
    logic [3:0] hlen;
    logic [7:0] d;

    // Buffer is free when empty or its final result leaves this cycle.
    logic drain_last;
    assign drain_last = out_valid && out_ready && (pos_reg + 2'd1 == cnt_reg);
    assign q_ready    = (cnt_reg == 2'd0) || drain_last;
    assign take       = q_valid && q_ready;
    assign out_valid  = (cnt_reg != 2'd0);
    assign out_res    = buf_reg[pos_reg];
    assign d          = q_item.data;

    function automatic logic [7:0] hdr(input logic [2:0] op, input logic [3:0] idx,
                                       input logic [ADDR_BITS-1:0] a);
        logic [23:0] a24;
        logic [7:0]  r;
        begin
            a24 = 24'(a);
            if (idx == 4'd0)      r = opcode(op);
            else if (op == 3'd1)  r = (idx == 4'd3) ? OP_ZERO : OP_DUMMY;
            else if (idx == 4'd1) r = a24[23:16];
            else if (idx == 4'd2) r = a24[15:8];
            else                  r = a24[7:0];
            return r;
        end
    endfunction

    always_comb
    begin
        logic [ADDR_BITS-1:0] na;
        logic [3:0]           fi;
        logic [23:0]          acc;
        phase_next = phase_reg;
        op_next    = op_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        fidx_next  = fidx_reg;
        acc_next   = acc_reg;
        n          = 2'd0;
        na         = addr_reg + 1'b1;
        fi         = fidx_reg + 4'd1;
        acc        = {acc_reg[15:0], d};
        for (int i = 0; i < 3; i++)
        begin
            buf_next[i] = '{kind: KIND_DONE, value: 24'd0, last: 1'b0, status: 1'b0};
        end
        hlen = (op_reg == 3'd0 || op_reg == 3'd7) ? 4'd1 : 4'd4;
        case (phase_reg)
            PH_IDLE:  ok = (q_item.cmd <= CMD_CHIP);
            PH_WAITW: ok = (q_item.cmd == CMD_WRITE);
            default:  ok = (q_item.cmd == CMD_LINK);
        endcase

        if (!ok)
        begin
            buf_next[0] = '{kind: KIND_DONE, value: 24'd0, last: 1'b0, status: 1'b1};
            n = 2'd1;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    op_next   = q_item.cmd[2:0];
                    addr_next = q_item.address[ADDR_BITS-1:0];
                    left_next = q_item.length;
                    fidx_next = 4'd0;
                    acc_next  = 24'd0;
                    n         = 2'd1;
                    if (q_item.cmd[2:0] <= 3'd2)
                    begin
                        buf_next[0].kind  = KIND_SEND;
                        buf_next[0].value = {16'd0, opcode(q_item.cmd[2:0])};
                        phase_next = PH_HDR;
                    end
                    else if (q_item.cmd[2:0] == 3'd3 && q_item.length == 16'd0)
                    begin
                        buf_next[0].kind = KIND_DONE;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        buf_next[0].kind  = KIND_SEND;
                        buf_next[0].value = {16'd0, OP_WREN};
                        phase_next = PH_WREN;
                    end
                end
                PH_WAITW:
                begin
                    buf_next[0].kind  = KIND_SEND;
                    buf_next[0].value = {16'd0, d};
                    n = 2'd1;
                    phase_next = PH_WDATA;
                end
                PH_WREN:
                begin
                    buf_next[0].kind = KIND_RELEASE;
                    buf_next[1].kind = KIND_SEND;
                    n = 2'd2;
                    if (op_reg == 3'd4)
                    begin
                        buf_next[1].value = {16'd0, OP_RDSR};
                        fidx_next  = 4'd1;
                        phase_next = PH_POLLC;
                    end
                    else
                    begin
                        buf_next[1].value = {16'd0, opcode(op_reg)};
                        fidx_next  = 4'd0;
                        phase_next = PH_HDR;
                    end
                end
                PH_HDR:
                begin
                    fidx_next = fi;
                    if (fi < hlen)
                    begin
                        buf_next[0].kind  = KIND_SEND;
                        buf_next[0].value = {16'd0, hdr(op_reg, fi, addr_reg)};
                        n = 2'd1;
                    end
                    else if (op_reg <= 3'd1)
                    begin
                        fidx_next = 4'd0;
                        acc_next  = 24'd0;
                        buf_next[0].kind  = KIND_SEND;
                        buf_next[0].value = {16'd0, OP_DUMMY};
                        n = 2'd1;
                        phase_next = PH_IDRD;
                    end
                    else if (op_reg == 3'd2)
                    begin
                        if (left_reg == 16'd0)
                        begin
                            buf_next[0].kind = KIND_RELEASE;
                            buf_next[1].kind = KIND_DONE;
                            n = 2'd2;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            buf_next[0].kind  = KIND_SEND;
                            buf_next[0].value = {16'd0, OP_DUMMY};
                            n = 2'd1;
                            phase_next = PH_RDATA;
                        end
                    end
                    else if (op_reg == 3'd3)
                    begin
                        phase_next = PH_WAITW;
                    end
                    else
                    begin
                        buf_next[0].kind  = KIND_RELEASE;
                        buf_next[1].kind  = KIND_SEND;
                        buf_next[1].value = {16'd0, OP_RDSR};
                        n = 2'd2;
                        fidx_next  = 4'd0;
                        phase_next = PH_POLLC;
                    end
                end
                PH_IDRD:
                begin
                    acc_next  = acc;
                    fidx_next = fi;
                    if (fi < ((op_reg == 3'd0) ? 4'd3 : 4'd2))
                    begin
                        buf_next[0].kind  = KIND_SEND;
                        buf_next[0].value = {16'd0, OP_DUMMY};
                        n = 2'd1;
                    end
                    else
                    begin
                        buf_next[0].kind  = KIND_RELEASE;
                        buf_next[1].kind  = KIND_DONE;
                        buf_next[1].value = acc;
                        n = 2'd2;
                        phase_next = PH_IDLE;
                    end
                end
                PH_RDATA:
                begin
                    buf_next[0].kind  = KIND_READ;
                    buf_next[0].value = {16'd0, d};
                    left_next = left_reg - 16'd1;
                    addr_next = na;
                    n = 2'd2;
                    if (left_reg != 16'd1)
                    begin
                        buf_next[1].kind  = KIND_SEND;
                        buf_next[1].value = {16'd0, OP_DUMMY};
                    end
                    else
                    begin
                        buf_next[1].kind = KIND_RELEASE;
                        buf_next[2].kind = KIND_DONE;
                        n = 2'd3;
                        phase_next = PH_IDLE;
                    end
                end
                PH_WDATA:
                begin
                    left_next = left_reg - 16'd1;
                    addr_next = na;
                    if (left_reg == 16'd1 || na[PW-1:0] == '0)
                    begin
                        buf_next[0].kind  = KIND_RELEASE;
                        buf_next[1].kind  = KIND_SEND;
                        buf_next[1].value = {16'd0, OP_RDSR};
                        n = 2'd2;
                        fidx_next  = 4'd0;
                        phase_next = PH_POLLC;
                    end
                    else
                    begin
                        phase_next = PH_WAITW;
                    end
                end
                PH_POLLC:
                begin
                    buf_next[0].kind  = KIND_SEND;
                    buf_next[0].value = {16'd0, OP_DUMMY};
                    n = 2'd1;
                    phase_next = PH_POLLS;
                end
                default:
                begin
                    if (d[0])
                    begin
                        buf_next[0].kind  = KIND_SEND;
                        buf_next[0].value = {16'd0, OP_DUMMY};
                        n = 2'd1;
                    end
                    else
                    begin
                        buf_next[0].kind = KIND_RELEASE;
                        n = 2'd2;
                        if (fidx_reg == 4'd1)
                        begin
                            buf_next[1].kind  = KIND_SEND;
                            buf_next[1].value = {16'd0, opcode(op_reg)};
                            fidx_next  = 4'd0;
                            phase_next = PH_HDR;
                        end
                        else if (op_reg == 3'd3 && left_reg != 16'd0)
                        begin
                            buf_next[1].kind  = KIND_SEND;
                            buf_next[1].value = {16'd0, OP_WREN};
                            phase_next = PH_WREN;
                        end
                        else
                        begin
                            buf_next[1].kind = KIND_DONE;
                            phase_next = PH_IDLE;
                        end
                    end
                end
            endcase
        end
        if (n != 2'd0)
        begin
            buf_next[n - 2'd1].last = 1'b1;
        end
        cnt_next = n;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < 3; i++)
            begin
                buf_reg[i] <= buf_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            op_reg    <= 3'd0;
            addr_reg  <= '0;
            left_reg  <= 16'd0;
            fidx_reg  <= 4'd0;
            acc_reg   <= 24'd0;
            cnt_reg   <= 2'd0;
            pos_reg   <= 2'd0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            addr_reg  <= addr_next;
            left_reg  <= left_next;
            fidx_reg  <= fidx_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= 2'd0;
        end
        else if (out_valid && out_ready)
        begin
            if (drain_last)
            begin
                cnt_reg <= 2'd0;
                pos_reg <= 2'd0;
            end
            else
            begin
                pos_reg <= pos_reg + 2'd1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pos_reg < cnt_reg))
        else $error("result position past buffer fill");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_res.status) |-> (out_res.last && out_res.kind == KIND_DONE))
        else $error("error result malformed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pos_reg)))
        else $error("stalled result moved");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_res.last) |-> (pos_reg + 2'd1 == cnt_reg))
        else $error("last flag not on final result");

endmodule

@@ rtl/spi_nor_flash_command_sequencer.sv @@
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer
// Byte-level sequencer for JEDEC ID, device ID, read, program and erases.
// ----------------------------------------------------------------------------
// Path: an input transaction is registered in the front-end queue, and its
// results in the back-end buffer. Throughput: one transaction per cycle while
// each causes at most one result and the receiver does not stall; an item with
// more results holds the back end until the single result port drains them.
// Reset: rst_n is asynchronous and active low; it returns the sequencer to
// idle and empties both the input queue and the result buffer.
module spi_nor_flash_command_sequencer
    import snfc_pkg::*;
#(
    parameter int PAGE_BYTES = 256,
    parameter int ADDR_BITS  = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // cmd[3:0], address[27:4], length[43:28], data[51:44]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // kind[1:0], value[25:2], status[26], zero fill
    output logic        m_axis_tlast   // last result caused by the input transaction
);

    item_t   in_item, q_item;
    result_t res;
    logic    q_valid, q_ready;

    // Unpack the slave transaction; the upper four bits are byte padding.
    assign in_item.cmd     = s_axis_tdata[3:0];
    assign in_item.address = s_axis_tdata[27:4];
    assign in_item.length  = s_axis_tdata[43:28];
    assign in_item.data    = s_axis_tdata[51:44];

    // The front end decouples input acceptance from command execution.
    snfc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    // The back end walks the flash command frames and buffers the results.
    snfc_back #(
        .PAGE_BYTES (PAGE_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {5'd0, res.status, res.value, res.kind};
    assign m_axis_tlast = res.last;

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the SPI NOR flash command sequencer
// Runs host commands and flash link returns through the sequencer and checks
// every result transaction against a behavioral predictor kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import snfc_pkg::*;

    localparam int PAGE_BYTES = 256;
    localparam int ADDR_BITS  = 24;

    // Sequencer phases as tracked by the predictor.
    typedef enum logic [3:0] {
        SQ_IDLE, SQ_WREN, SQ_HDR, SQ_IDRD, SQ_RDATA, SQ_WAITW, SQ_WDATA, SQ_POLLC, SQ_POLLS
    } seq_phase_e;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // cmd, address, length, data from the lowest bit up
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // kind, value, status, zero fill from the lowest bit up
    logic        m_axis_tlast;

    spi_nor_flash_command_sequencer #(.PAGE_BYTES(PAGE_BYTES), .ADDR_BITS(ADDR_BITS)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // Predictor state.
    seq_phase_e  seq_phase;
    logic [2:0]  seq_op;
    logic [23:0] seq_addr;
    logic [15:0] seq_left;
    logic [3:0]  seq_frame;
    logic [23:0] seq_id;

    result_t expected_results[$];
    result_t step_buf[$];
    int      errors;
    int      send_idle_pct;
    int      recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit: far beyond the slowest correct run.
    initial
    begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [7:0] op_byte(input logic [2:0] op);
        logic [7:0] b;
        case (op)
            3'd0:    b = 8'h9F;
            3'd1:    b = 8'h90;
            3'd2:    b = 8'h03;
            3'd3:    b = 8'h02;
            3'd4:    b = 8'h20;
            3'd5:    b = 8'h52;
            3'd6:    b = 8'hD8;
            default: b = 8'hC7;
        endcase
        return b;
    endfunction

    // Header byte idx of the current command frame.
    function automatic logic [7:0] header_byte(input logic [3:0] idx);
        logic [7:0] b;
        if (idx == 4'd0)
            b = op_byte(seq_op);
        else if (seq_op == 3'd1)
            b = (idx == 4'd3) ? OP_ZERO : OP_DUMMY;
        else if (idx == 4'd1)
            b = seq_addr[23:16];
        else if (idx == 4'd2)
            b = seq_addr[15:8];
        else
            b = seq_addr[7:0];
        return b;
    endfunction

    task automatic emit(input logic [1:0] kind, input logic [23:0] value);
        result_t r;
        r.kind = kind;
        r.value = value;
        r.last = 1'b0;
        r.status = 1'b0;
        if (step_buf.size() < 3)
            step_buf.push_back(r);
    endtask

    task automatic emit_byte(input logic [1:0] kind, input logic [7:0] b);
        emit(kind, {16'd0, b});
    endtask

    task automatic begin_poll(input logic [3:0] pre);
        emit_byte(KIND_SEND, OP_RDSR);
        seq_frame = pre;
        seq_phase = SQ_POLLC;
    endtask

    task automatic begin_header();
        seq_frame = 4'd0;
        emit_byte(KIND_SEND, header_byte(4'd0));
        seq_phase = SQ_HDR;
    endtask

    task automatic link_return(input logic [7:0] d);
        logic [3:0] hlen;
        case (seq_phase)
            SQ_WREN:
            begin
                emit(KIND_RELEASE, 24'd0);
                if (seq_op == 3'd4)
                    begin_poll(4'd1);
                else
                    begin_header();
            end
            SQ_HDR:
            begin
                hlen = (seq_op == 3'd0 || seq_op == 3'd7) ? 4'd1 : 4'd4;
                seq_frame = seq_frame + 4'd1;
                if (seq_frame < hlen)
                    emit_byte(KIND_SEND, header_byte(seq_frame));
                else if (seq_op <= 3'd1)
                begin
                    seq_frame = 4'd0;
                    seq_id = 24'd0;
                    emit_byte(KIND_SEND, OP_DUMMY);
                    seq_phase = SQ_IDRD;
                end
                else if (seq_op == 3'd2)
                begin
                    if (seq_left == 16'd0)
                    begin
                        emit(KIND_RELEASE, 24'd0);
                        emit(KIND_DONE, 24'd0);
                        seq_phase = SQ_IDLE;
                    end
                    else
                    begin
                        emit_byte(KIND_SEND, OP_DUMMY);
                        seq_phase = SQ_RDATA;
                    end
                end
                else if (seq_op == 3'd3)
                    seq_phase = SQ_WAITW;
                else
                begin
                    emit(KIND_RELEASE, 24'd0);
                    begin_poll(4'd0);
                end
            end
            SQ_IDRD:
            begin
                seq_id = {seq_id[15:0], d};
                seq_frame = seq_frame + 4'd1;
                if (seq_frame < ((seq_op == 3'd0) ? 4'd3 : 4'd2))
                    emit_byte(KIND_SEND, OP_DUMMY);
                else
                begin
                    emit(KIND_RELEASE, 24'd0);
                    emit(KIND_DONE, seq_id);
                    seq_phase = SQ_IDLE;
                end
            end
            SQ_RDATA:
            begin
                emit_byte(KIND_READ, d);
                seq_left = seq_left - 16'd1;
                seq_addr = seq_addr + 24'd1;
                if (seq_left != 16'd0)
                    emit_byte(KIND_SEND, OP_DUMMY);
                else
                begin
                    emit(KIND_RELEASE, 24'd0);
                    emit(KIND_DONE, 24'd0);
                    seq_phase = SQ_IDLE;
                end
            end
            SQ_WDATA:
            begin
                seq_left = seq_left - 16'd1;
                seq_addr = seq_addr + 24'd1;
                if (seq_left == 16'd0 || (seq_addr % PAGE_BYTES) == 0)
                begin
                    emit(KIND_RELEASE, 24'd0);
                    begin_poll(4'd0);
                end
                else
                    seq_phase = SQ_WAITW;
            end
            SQ_POLLC:
            begin
                emit_byte(KIND_SEND, OP_DUMMY);
                seq_phase = SQ_POLLS;
            end
            default:
            begin
                if (d[0])
                    emit_byte(KIND_SEND, OP_DUMMY);
                else
                begin
                    emit(KIND_RELEASE, 24'd0);
                    if (seq_frame == 4'd1)
                        begin_header();
                    else if (seq_op == 3'd3 && seq_left != 16'd0)
                    begin
                        emit_byte(KIND_SEND, OP_WREN);
                        seq_phase = SQ_WREN;
                    end
                    else
                    begin
                        emit(KIND_DONE, 24'd0);
                        seq_phase = SQ_IDLE;
                    end
                end
            end
        endcase
    endtask

    // Work out the results of one accepted transaction and queue them.
    task automatic predict_transaction(input item_t it);
        logic accepted;
        step_buf.delete();
        if (seq_phase == SQ_IDLE)
            accepted = (it.cmd <= CMD_CHIP);
        else if (seq_phase == SQ_WAITW)
            accepted = (it.cmd == CMD_WRITE);
        else
            accepted = (it.cmd == CMD_LINK);

        if (!accepted)
        begin
            emit(KIND_DONE, 24'd0);
            step_buf[0].status = 1'b1;
        end
        else if (seq_phase == SQ_IDLE)
        begin
            seq_op = it.cmd[2:0];
            seq_addr = it.address;
            seq_left = it.length;
            seq_frame = 4'd0;
            seq_id = 24'd0;
            if (seq_op <= 3'd2)
                begin_header();
            else if (seq_op == 3'd3 && seq_left == 16'd0)
                emit(KIND_DONE, 24'd0);
            else
            begin
                emit_byte(KIND_SEND, OP_WREN);
                seq_phase = SQ_WREN;
            end
        end
        else if (seq_phase == SQ_WAITW)
        begin
            emit_byte(KIND_SEND, it.data);
            seq_phase = SQ_WDATA;
        end
        else
            link_return(it.data);

        if (step_buf.size() > 0)
            step_buf[step_buf.size() - 1].last = 1'b1;
        foreach (step_buf[i])
            expected_results.push_back(step_buf[i]);
    endtask

    // Send one transaction, with a random gap before it. The valid flag stays
    // high after acceptance so that back to back transactions need no gap.
    task automatic send_item(input logic [3:0] cmd, input logic [23:0] address,
                             input logic [15:0] length, input logic [7:0] data);
        item_t it;
        it.cmd = cmd;
        it.address = address;
        it.length = length;
        it.data = data;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, it.data, it.length, it.address, it.cmd};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_transaction(it);
    endtask

    task automatic link(input logic [7:0] d);
        send_item(CMD_LINK, 24'($urandom), 16'($urandom), d);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Answer the sequencer until it goes idle; busy_pct sets how often the
    // status poll reports the flash still busy.
    task automatic finish_job(input int busy_pct);
        int guard;
        guard = 0;
        while (seq_phase != SQ_IDLE && guard < 4000)
        begin
            guard++;
            if (seq_phase == SQ_WAITW)
                send_item(CMD_WRITE, 24'($urandom), 16'($urandom), 8'($urandom));
            else if (seq_phase == SQ_POLLS)
                link({7'($urandom_range(127, 0)), ($urandom_range(99, 0) < busy_pct)});
            else
                link(8'($urandom));
        end
    endtask

    task automatic run_command(input logic [3:0] cmd, input logic [23:0] address,
                               input logic [15:0] length);
        send_item(cmd, address, length, 8'($urandom));
        finish_job(30);
    endtask

    // Checker: one result transaction against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result kind=%0d value=%h", m_axis_tdata[1:0],
                       m_axis_tdata[25:2]);
                errors++;
            end
            else
            begin
                result_t e;
                e = expected_results.pop_front();
                if (m_axis_tdata[1:0] !== e.kind)
                begin
                    $error("kind expected %0d actual %0d", e.kind, m_axis_tdata[1:0]);
                    errors++;
                end
                if (m_axis_tdata[25:2] !== e.value)
                begin
                    $error("value expected %h actual %h", e.value, m_axis_tdata[25:2]);
                    errors++;
                end
                if (m_axis_tlast !== e.last)
                begin
                    $error("last expected %0d actual %0d", e.last, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tdata[26] !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, m_axis_tdata[26]);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);

    // Identification reads, both identification header paths, and id byte extremes.
    task automatic test_identification();
        send_item(CMD_JEDEC, 24'hFFFFFF, 16'hFFFF, 8'hFF);
        link(8'h00);
        link(8'hFF);
        link(8'h00);
        link(8'hFF);
        run_command(CMD_DEVID, 24'h000000, 16'h0000);
    endtask

    // Reads: empty, and a three-byte read across the top of the address space.
    task automatic test_reads();
        run_command(CMD_READ, 24'h000000, 16'd0);
        run_command(CMD_READ, 24'hFFFFFF, 16'd3);
    endtask

    // Programs: empty, across a page boundary, and all erase kinds.
    task automatic test_program_erase();
        run_command(CMD_PROGRAM, 24'h123456, 16'd0);
        run_command(CMD_PROGRAM, 24'hFFFFFE, 16'd4);
        run_command(CMD_SECTOR, 24'hABCDEF, 16'd0);
        run_command(CMD_ERASE32, 24'h5A5A5A, 16'd0);
        run_command(CMD_ERASE64, 24'hA5A5A5, 16'd0);
        run_command(CMD_CHIP, 24'h000000, 16'd0);
    endtask

    // Items that arrive in the wrong phase are flagged and ignored.
    task automatic test_unexpected();
        send_item(4'd15, 24'hFFFFFF, 16'hFFFF, 8'hFF);
        send_item(CMD_WRITE, 24'd0, 16'd0, 8'd0);
        send_item(CMD_LINK, 24'd0, 16'd0, 8'd0);
        send_item(CMD_PROGRAM, 24'h0000F0, 16'd2, 8'd0);
        send_item(CMD_READ, 24'd0, 16'd0, 8'd0);    // new command while busy
        link(8'h00);
        link(8'h00);
        link(8'h00);
        link(8'h00);
        link(8'h00);
        send_item(CMD_LINK, 24'd0, 16'd0, 8'd0);    // write byte is due
        finish_job(20);
    endtask

    // Random jobs, mostly well formed with small sizes, some noise.
    task automatic test_random_jobs(input int count);
        logic [3:0] cmd;
        logic [15:0] len;
        for (int i = 0; i < count; i++)
        begin
            cmd = 4'($urandom_range(7, 0));
            len = ($urandom_range(9, 0) == 0) ? 16'($urandom_range(16, 0))
                                               : 16'($urandom_range(6, 0));
            if ($urandom_range(9, 0) == 0)
                send_item(4'($urandom_range(15, 8)), 24'($urandom), 16'($urandom),
                          8'($urandom));
            send_item(cmd, 24'($urandom), len, 8'($urandom));
            if (seq_phase != SQ_IDLE && $urandom_range(9, 0) == 0)
                send_item(4'($urandom_range(15, 0)), 24'($urandom), 16'($urandom),
                          8'($urandom));
            finish_job(40);
        end
    endtask

    initial
    begin
        errors = 0;
        send_idle_pct = 35;
        recv_stall_pct = 76;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        seq_phase = SQ_IDLE;
        seq_op = 3'd0;
        seq_addr = 24'd0;
        seq_left = 16'd0;
        seq_frame = 4'd0;
        seq_id = 24'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_identification();
        test_reads();
        test_program_erase();
        test_unexpected();
        wait_drained();             // sender holds off until all results are in

        test_random_jobs(4);
        send_idle_pct = 76;
        recv_stall_pct = 35;
        test_random_jobs(4);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_jobs(4);

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
rtl/snfc_pkg.sv
rtl/snfc_front.sv
rtl/snfc_back.sv
rtl/spi_nor_flash_command_sequencer.sv
bench/tb_top.sv
